FILE: rtl/trwl_pkg.sv
// shared types, codes and sizing functions of the trie word lookup
`default_nettype none

package trwl_pkg;

  localparam int BRANCH_NODES_DEF  = 4096;
  localparam int SINGLE_NODES_DEF  = 65536;
  localparam int ALPHABET_SIZE_DEF = 64;

  // a 16-bit node index and a 17-bit reference reach at most this many single nodes
  localparam int SINGLE_NODES_REACH = 65536;

  localparam logic [7:0] SKIP_CODE_RST = 8'd254;
  localparam logic [7:0] STOP_CODE_RST = 8'd253;
  localparam logic [7:0] END_CODE_RST  = 8'd255;

  localparam logic signed [20:0] LIST_NONE = -21'sd1;

  typedef enum logic [1:0] {
    REQ_SET_CHILD  = 2'd0,
    REQ_SET_LIST   = 2'd1,
    REQ_SET_SINGLE = 2'd2,
    REQ_QUERY      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CFG_SKIP = 2'd0,
    CFG_STOP = 2'd1,
    CFG_END  = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic [7:0]         ch;
    logic signed [16:0] next;
    logic [19:0]        list;
  } single_entry_t;

  // branch rows hold the child slots followed by the list id slot
  function automatic int branch_depth(int nodes, int alphabet);
    return nodes * (alphabet + 1);
  endfunction

  function automatic int single_depth(int nodes);
    return (nodes < SINGLE_NODES_REACH) ? nodes : SINGLE_NODES_REACH;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/trwl_branch_store.sv
// branch node memory: child references and list ids, with clearing pass after reset
`default_nettype none

module trwl_branch_store #(
  parameter int BRANCH_NODES  = trwl_pkg::BRANCH_NODES_DEF,
  parameter int ALPHABET_SIZE = trwl_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  trwl_pkg::mem_ctl_t        ctl_i,
  input  logic [$clog2(trwl_pkg::branch_depth(BRANCH_NODES, ALPHABET_SIZE))-1:0] addr_i,
  input  logic [19:0]               wdata_i,
  output logic [19:0]               rdata_o,
  output logic                      busy_o
);
  import trwl_pkg::*;

  localparam int DEPTH = branch_depth(BRANCH_NODES, ALPHABET_SIZE);
  localparam int AW    = $clog2(DEPTH);

  logic [19:0]   mem_q [DEPTH];
  logic [19:0]   rdata_q;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          busy_q, busy_d;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [19:0]   wr_data;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  assign wr_en   = busy_q || ctl_i.we;
  assign wr_addr = busy_q ? clr_cnt_q : addr_i;
  assign wr_data = busy_q ? 20'd0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

FILE: rtl/trwl_single_store.sv
// single-character node memory: expected character, next reference and list id
`default_nettype none

module trwl_single_store #(
  parameter int SINGLE_NODES = trwl_pkg::SINGLE_NODES_DEF
) (
  input  logic                    clk_i,
  input  trwl_pkg::mem_ctl_t      ctl_i,
  input  logic [$clog2(trwl_pkg::single_depth(SINGLE_NODES))-1:0] addr_i,
  input  trwl_pkg::single_entry_t wdata_i,
  output trwl_pkg::single_entry_t rdata_o
);
  import trwl_pkg::*;

  localparam int DEPTH = single_depth(SINGLE_NODES);

  single_entry_t mem_q [DEPTH];
  single_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/trwl_ctrl.sv
// walk sequencer: code registers, walk state, table access and result register
`default_nettype none

module trwl_ctrl #(
  parameter int BRANCH_NODES  = trwl_pkg::BRANCH_NODES_DEF,
  parameter int SINGLE_NODES  = trwl_pkg::SINGLE_NODES_DEF,
  parameter int ALPHABET_SIZE = trwl_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [7:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic [15:0]             node_index_i,
  input  logic [7:0]              symbol_i,
  input  logic signed [16:0]      child_ref_i,
  input  logic [19:0]             list_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [20:0]      list_found_o,
  input  logic                    clear_busy_i,
  output trwl_pkg::mem_ctl_t      b_ctl_o,
  output logic [$clog2(trwl_pkg::branch_depth(BRANCH_NODES, ALPHABET_SIZE))-1:0] b_addr_o,
  output logic [19:0]             b_wdata_o,
  input  logic [19:0]             b_rdata_i,
  output trwl_pkg::mem_ctl_t      s_ctl_o,
  output logic [$clog2(trwl_pkg::single_depth(SINGLE_NODES))-1:0] s_addr_o,
  output trwl_pkg::single_entry_t s_wdata_o,
  input  trwl_pkg::single_entry_t s_rdata_i
);
  import trwl_pkg::*;

  localparam int ROW    = ALPHABET_SIZE + 1;
  localparam int AW     = $clog2(branch_depth(BRANCH_NODES, ALPHABET_SIZE));
  localparam int BW     = $clog2(BRANCH_NODES);
  localparam int SDEPTH = single_depth(SINGLE_NODES);
  localparam int SW     = $clog2(SDEPTH);

  state_e            state_q, state_d;
  logic [7:0]        skip_q, skip_d, stop_q, stop_d, end_q, end_d;
  logic              cur_single_q, cur_single_d;
  logic [BW-1:0]     cur_b_q, cur_b_d;
  logic [SW-1:0]     cur_s_q, cur_s_d;
  logic              entered_q, entered_d;
  logic              failed_q, failed_d;
  logic              list_pend_q, list_pend_d;
  logic              pend_single_q, pend_single_d;
  logic [19:0]       cur_list_q, cur_list_d;
  logic signed [20:0] emit_list_q, emit_list_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        sym_q, sym_d;
  logic signed [20:0] list_q, list_d;

  req_type_e     req_e;
  logic          accept, is_query, sym_end, sym_skip, sym_term, sym_in_alpha;
  logic          q_step, q_term, term_neg, out_free, walk_phase;
  logic [BW-1:0] idx_sel;
  logic [7:0]    slot_sel;
  logic [16:0]   r_u;
  logic          miss;
  logic [15:0]   s_idx;
  logic [19:0]   pend_list;

  assign req_e        = req_type_e'(req_type_i);
  assign in_stall_o   = clear_busy_i || (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign is_query     = (req_e == REQ_QUERY);
  assign sym_end      = (symbol_i == end_q);
  assign sym_skip     = !sym_end && (symbol_i == skip_q);
  assign sym_term     = sym_end || (!sym_skip && (symbol_i == stop_q));
  assign sym_in_alpha = (symbol_i < 8'(ALPHABET_SIZE));
  assign q_step       = accept && is_query && !sym_skip && !sym_term && !failed_q
                        && sym_in_alpha;
  assign q_term       = accept && is_query && sym_term;
  assign term_neg     = failed_q || !entered_q;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign walk_phase   = (state_q == ST_WALK);

  // table addresses; the step cycle reads the list id of the node entered
  assign idx_sel   = walk_phase ? r_u[BW-1:0] :
                     (is_query ? cur_b_q : node_index_i[BW-1:0]);
  assign slot_sel  = (walk_phase || (req_e == REQ_SET_LIST)) ? 8'(ALPHABET_SIZE) : symbol_i;
  assign b_addr_o  = AW'(idx_sel) * AW'(ROW) + AW'(slot_sel);
  assign s_addr_o  = walk_phase ? s_idx[SW-1:0] :
                     (is_query ? cur_s_q : node_index_i[SW-1:0]);
  assign b_wdata_o = (req_e == REQ_SET_LIST) ? list_value_i : {3'b000, child_ref_i};
  assign s_wdata_o = '{ch: symbol_i, next: child_ref_i, list: list_value_i};

  // step result from the table word read for the current node
  assign r_u   = cur_single_q ? s_rdata_i.next : b_rdata_i[16:0];
  assign miss  = cur_single_q ? (s_rdata_i.ch != sym_q) : (b_rdata_i[16:0] == 17'd0);
  assign s_idx = ~r_u[15:0];

  // list id of the node entered by the last step
  assign pend_list = pend_single_q ? s_rdata_i.list : b_rdata_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_step) begin
          state_d = ST_WALK;
        end else if (q_term) begin
          state_d = ST_EMIT;
        end
      end
      ST_WALK: state_d = ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    skip_d        = skip_q;
    stop_d        = stop_q;
    end_d         = end_q;
    cur_single_d  = cur_single_q;
    cur_b_d       = cur_b_q;
    cur_s_d       = cur_s_q;
    entered_d     = entered_q;
    failed_d      = failed_q;
    list_pend_d   = 1'b0;
    pend_single_d = pend_single_q;
    cur_list_d    = list_pend_q ? pend_list : cur_list_q;
    emit_list_d   = emit_list_q;
    sym_d         = sym_q;
    list_d        = list_q;
    out_valid_d   = out_valid_q && out_stall_i;
    b_ctl_o       = '0;
    s_ctl_o       = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SKIP: skip_d = cfg_wdata_i;
        CFG_STOP: stop_d = cfg_wdata_i;
        CFG_END:  end_d  = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_e)
            REQ_SET_CHILD: begin
              b_ctl_o.we = ({1'b0, node_index_i} < 17'(BRANCH_NODES)) && sym_in_alpha;
            end
            REQ_SET_LIST: begin
              b_ctl_o.we = ({1'b0, node_index_i} < 17'(BRANCH_NODES));
            end
            REQ_SET_SINGLE: begin
              s_ctl_o.we = ({1'b0, node_index_i} < 17'(SDEPTH));
            end
            REQ_QUERY: begin
              if (sym_term) begin
                emit_list_d  = term_neg ? LIST_NONE : {1'b0, cur_list_d};
                cur_single_d = 1'b0;
                cur_b_d      = '0;
                entered_d    = 1'b0;
                failed_d     = 1'b0;
              end else if (!sym_skip && !failed_q) begin
                if (!sym_in_alpha) begin
                  failed_d = 1'b1;
                end else begin
                  sym_d      = symbol_i;
                  b_ctl_o.re = !cur_single_q;
                  s_ctl_o.re = cur_single_q;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (miss) begin
          failed_d = 1'b1;
        end else if (!r_u[16]) begin
          if (r_u >= 17'(BRANCH_NODES)) begin
            failed_d = 1'b1;
          end else begin
            cur_single_d  = 1'b0;
            cur_b_d       = r_u[BW-1:0];
            entered_d     = 1'b1;
            b_ctl_o.re    = 1'b1;
            list_pend_d   = 1'b1;
            pend_single_d = 1'b0;
          end
        end else begin
          if ({1'b0, s_idx} >= 17'(SDEPTH)) begin
            failed_d = 1'b1;
          end else begin
            cur_single_d  = 1'b1;
            cur_s_d       = s_idx[SW-1:0];
            entered_d     = 1'b1;
            s_ctl_o.re    = 1'b1;
            list_pend_d   = 1'b1;
            pend_single_d = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          list_d      = emit_list_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      skip_q        <= SKIP_CODE_RST;
      stop_q        <= STOP_CODE_RST;
      end_q         <= END_CODE_RST;
      cur_single_q  <= 1'b0;
      cur_b_q       <= '0;
      cur_s_q       <= '0;
      entered_q     <= 1'b0;
      failed_q      <= 1'b0;
      list_pend_q   <= 1'b0;
      pend_single_q <= 1'b0;
      emit_list_q   <= LIST_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      skip_q        <= skip_d;
      stop_q        <= stop_d;
      end_q         <= end_d;
      cur_single_q  <= cur_single_d;
      cur_b_q       <= cur_b_d;
      cur_s_q       <= cur_s_d;
      entered_q     <= entered_d;
      failed_q      <= failed_d;
      list_pend_q   <= list_pend_d;
      pend_single_q <= pend_single_d;
      emit_list_q   <= emit_list_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    list_q     <= list_d;
    cur_list_q <= cur_list_d;
  end

  assign out_valid_o  = out_valid_q;
  assign list_found_o = list_q;

endmodule

`default_nettype wire

FILE: rtl/trie_word_lookup.sv
// trie word lookup: walks query symbols through branch and single-character node tables
// write items do not stall; a walking query symbol reads its node, then the list id of the node it enters
// skip symbols, symbols outside the alphabet and symbols after a failure do not stall
// a stop or end symbol enters the emit state, which holds while a result waits, then registers it
// reset runs a clearing pass over the branch table with input stalled;
// code registers are writable throughout
`default_nettype none

module trie_word_lookup #(
  parameter int BRANCH_NODES  = trwl_pkg::BRANCH_NODES_DEF,
  parameter int SINGLE_NODES  = trwl_pkg::SINGLE_NODES_DEF,
  parameter int ALPHABET_SIZE = trwl_pkg::ALPHABET_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        node_index_i,
  input  logic [7:0]         symbol_i,
  input  logic signed [16:0] child_ref_i,
  input  logic [19:0]        list_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [20:0] list_found_o
);
  import trwl_pkg::*;

  localparam int AW = $clog2(branch_depth(BRANCH_NODES, ALPHABET_SIZE));
  localparam int SW = $clog2(single_depth(SINGLE_NODES));

  mem_ctl_t      b_ctl, s_ctl;
  logic [AW-1:0] b_addr;
  logic [19:0]   b_wdata, b_rdata;
  logic [SW-1:0] s_addr;
  single_entry_t s_wdata, s_rdata;
  logic          clear_busy;

  trwl_ctrl #(
    .BRANCH_NODES (BRANCH_NODES),
    .SINGLE_NODES (SINGLE_NODES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .node_index_i(node_index_i),
    .symbol_i    (symbol_i),
    .child_ref_i (child_ref_i),
    .list_value_i(list_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .list_found_o(list_found_o),
    .clear_busy_i(clear_busy),
    .b_ctl_o     (b_ctl),
    .b_addr_o    (b_addr),
    .b_wdata_o   (b_wdata),
    .b_rdata_i   (b_rdata),
    .s_ctl_o     (s_ctl),
    .s_addr_o    (s_addr),
    .s_wdata_o   (s_wdata),
    .s_rdata_i   (s_rdata)
  );

  trwl_branch_store #(
    .BRANCH_NODES (BRANCH_NODES),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_branch_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (b_ctl),
    .addr_i (b_addr),
    .wdata_i(b_wdata),
    .rdata_o(b_rdata),
    .busy_o (clear_busy)
  );

  trwl_single_store #(
    .SINGLE_NODES(SINGLE_NODES)
  ) u_single_store (
    .clk_i  (clk_i),
    .ctl_i  (s_ctl),
    .addr_i (s_addr),
    .wdata_i(s_wdata),
    .rdata_o(s_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/trwl_checker.sv
// port-level checks of the trie word lookup, bound to the top level
`default_nettype none

module trwl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         req_type_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [20:0] list_found_o
);
  import trwl_pkg::*;

  logic in_xfer, write_xfer;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign write_xfer = in_xfer && (req_type_i != REQ_QUERY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(list_found_o))
    else $error("stalled result changed");

  a_list_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_found_o[20] |-> list_found_o == LIST_NONE)
    else $error("negative result other than no match");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_xfer && !out_valid_o |=> !out_valid_o)
    else $error("table write produced a result");

  a_write_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_xfer |=> !in_stall_o)
    else $error("table write held the input");

endmodule

bind trie_word_lookup trwl_checker u_checker (.*);

`default_nettype wire

FILE: tb/trie_word_lookup_tb.sv
// self-checking testbench of the trie word lookup with a built-in walk predictor
module trie_word_lookup_tb;
  import trwl_pkg::*;

  localparam int BR_NODES = BRANCH_NODES_DEF;
  localparam int SG_NODES = SINGLE_NODES_DEF;
  localparam int ALPH     = ALPHABET_SIZE_DEF;
  localparam int WD_LIMIT = 800000;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [1:0]         cfg_index_i  = CFG_SKIP;
  logic [7:0]         cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i   = REQ_QUERY;
  logic [15:0]        node_index_i = '0;
  logic [7:0]         symbol_i     = '0;
  logic signed [16:0] child_ref_i  = '0;
  logic [19:0]        list_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic signed [20:0] list_found_o;

  // predictor state
  bit signed [16:0]   child_tab [BR_NODES * ALPH];
  bit [19:0]          branch_list [BR_NODES];
  bit [7:0]           single_ch [SG_NODES];
  bit signed [16:0]   single_next [SG_NODES];
  bit [19:0]          single_list [SG_NODES];
  int                 walk_node = 0;
  logic signed [20:0] walk_list = LIST_NONE;
  bit                 walk_dead = 1'b0;
  logic [7:0]         code_skip = SKIP_CODE_RST;
  logic [7:0]         code_stop = STOP_CODE_RST;
  logic [7:0]         code_end  = END_CODE_RST;

  // nodes whose list (and, for single nodes, every field) has been written
  bit                 br_ok [BR_NODES];
  bit                 sg_ok [SG_NODES];
  int                 br_pool [$];
  int                 sg_pool [$];

  logic signed [20:0] pending_lists [$];
  logic signed [20:0] head_list;
  int                 fail_count  = 0;
  int                 items_sent  = 0;
  int                 idle_cycles = 0;
  bit                 idle_on     = 1'b1;

  trie_word_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .node_index_i (node_index_i),
    .symbol_i     (symbol_i),
    .child_ref_i  (child_ref_i),
    .list_value_i (list_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .list_found_o (list_found_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void predict_list_found(req_type_e rq, logic [15:0] nd, logic [7:0] sy,
                                             logic signed [16:0] rf, logic [19:0] lv);
    int nxt;
    nxt = 0;
    case (rq)
      REQ_SET_CHILD: begin
        if (nd < BR_NODES && sy < ALPH) child_tab[nd * ALPH + sy] = rf;
      end
      REQ_SET_LIST: begin
        if (nd < BR_NODES) begin
          branch_list[nd] = lv;
          if (!br_ok[nd]) begin
            br_ok[nd] = 1'b1;
            br_pool = {br_pool, int'(nd)};
          end
        end
      end
      REQ_SET_SINGLE: begin
        single_ch[nd]   = sy;
        single_next[nd] = rf;
        single_list[nd] = lv;
        if (!sg_ok[nd]) begin
          sg_ok[nd] = 1'b1;
          sg_pool = {sg_pool, int'(nd)};
        end
      end
      default: begin
        if (sy != code_end && sy == code_skip) return;
        if (sy == code_end || sy == code_stop) begin
          pending_lists = {pending_lists, walk_dead ? LIST_NONE : walk_list};
          walk_node = 0;
          walk_list = LIST_NONE;
          walk_dead = 1'b0;
        end else if (!walk_dead) begin
          if (sy >= ALPH) begin
            walk_dead = 1'b1;
          end else begin
            if (walk_node >= 0) begin
              nxt = child_tab[walk_node * ALPH + sy];
              if (nxt == 0) walk_dead = 1'b1;
            end else if (single_ch[-walk_node - 1] != sy) begin
              walk_dead = 1'b1;
            end else begin
              // a next of zero leads back to the root
              nxt = single_next[-walk_node - 1];
            end
            if (!walk_dead) begin
              if (nxt >= BR_NODES || (nxt < 0 && -nxt - 1 >= SG_NODES)) begin
                walk_dead = 1'b1;
              end else begin
                walk_node = nxt;
                walk_list = (nxt >= 0) ? {1'b0, branch_list[nxt]} : {1'b0, single_list[-nxt - 1]};
              end
            end
          end
        end
      end
    endcase
  endfunction

  // result checker and output stall
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_lists.size() == 0) begin
        if (fail_count < 10) $display("unexpected transfer: list_found %0d", list_found_o);
        fail_count++;
      end else begin
        head_list = pending_lists.pop_front();
        if (list_found_o !== head_list) begin
          if (fail_count < 10)
            $display("list_found mismatch: expected %0d, actual %0d", head_list, list_found_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= idle_on && ($urandom_range(99) < 28);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input req_type_e rq, input logic [15:0] nd, input logic [7:0] sy,
                           input logic signed [16:0] rf, input logic [19:0] lv);
    if (idle_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rq;
    node_index_i <= nd;
    symbol_i     <= sy;
    child_ref_i  <= rf;
    list_value_i <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_list_found(rq, nd, sy, rf, lv);
    items_sent++;
  endtask

  task automatic send_query(input logic [7:0] sy);
    send_item(REQ_QUERY, 16'($urandom), sy, 17'($urandom), 20'($urandom));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_lists.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_code(input cfg_index_e idx, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SKIP: code_skip = v;
      CFG_STOP: code_stop = v;
      default:  code_end  = v;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_codes(input logic [7:0] skip_v, input logic [7:0] stop_v,
                           input logic [7:0] end_v);
    settle();
    write_code(CFG_SKIP, skip_v);
    write_code(CFG_STOP, stop_v);
    write_code(CFG_END, end_v);
  endtask

  function automatic logic signed [16:0] pick_ref();
    int v;
    if ($urandom_range(1)) v = br_pool[$urandom_range(0, br_pool.size() - 1)];
    else v = -sg_pool[$urandom_range(0, sg_pool.size() - 1)] - 1;
    return 17'(v);
  endfunction

  // symbol that follows an existing edge from the current walk position, or a random alphabet symbol
  function automatic logic [7:0] path_symbol();
    logic [7:0] hits [$];
    if (walk_dead || $urandom_range(99) < 8) return 8'($urandom_range(0, ALPH - 1));
    if (walk_node < 0) return single_ch[-walk_node - 1];
    for (int s = 0; s < ALPH; s++)
      if (child_tab[walk_node * ALPH + s] != 0) hits = {hits, 8'(s)};
    if (hits.size() == 0) return 8'($urandom_range(0, ALPH - 1));
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  task automatic send_word(input bit tidy);
    int len;
    len = $urandom_range(0, 6);
    repeat (len) begin
      if ($urandom_range(99) < 8) send_query(code_skip);
      send_query(tidy ? path_symbol() : 8'($urandom));
    end
    send_query($urandom_range(1) ? code_stop : code_end);
  endtask

  task automatic send_table_write();
    int pick;
    logic [15:0] nd;
    pick = $urandom_range(99);
    if (pick < 45) begin
      nd = ($urandom_range(99) < 85) ? 16'(br_pool[$urandom_range(0, br_pool.size() - 1)])
                                     : 16'($urandom);
      send_item(REQ_SET_CHILD, nd,
                ($urandom_range(99) < 90) ? 8'($urandom_range(0, ALPH - 1)) : 8'($urandom),
                ($urandom_range(99) < 85) ? pick_ref() : 17'sd0, 20'($urandom));
    end else if (pick < 70) begin
      nd = ($urandom_range(99) < 70) ? 16'(br_pool[$urandom_range(0, br_pool.size() - 1)])
                                     : 16'($urandom);
      send_item(REQ_SET_LIST, nd, 8'($urandom), 17'($urandom), 20'($urandom));
    end else begin
      nd = ($urandom_range(99) < 70) ? 16'(sg_pool[$urandom_range(0, sg_pool.size() - 1)])
                                     : 16'($urandom);
      send_item(REQ_SET_SINGLE, nd,
                ($urandom_range(99) < 85) ? 8'($urandom_range(0, ALPH - 1)) : 8'($urandom),
                pick_ref(), 20'($urandom));
    end
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) send_table_write();
      else send_word($urandom_range(99) < 85);
    end
  endtask

  task automatic test_load_trie();
    send_item(REQ_SET_LIST, 16'd0, 8'd0, 17'sd0, 20'hFFFFF);
    send_item(REQ_SET_LIST, 16'd1, 8'hFF, -17'sd1, 20'd1);
    send_item(REQ_SET_LIST, 16'd4095, 8'd0, 17'sd0, 20'h0ABCD);
    send_item(REQ_SET_LIST, 16'hFFFF, 8'd0, 17'sd0, 20'h12345);
    send_item(REQ_SET_SINGLE, 16'hFFFF, 8'd63, 17'sd4095, 20'd0);
    send_item(REQ_SET_SINGLE, 16'd0, 8'd5, 17'sd0, 20'd100);
    send_item(REQ_SET_SINGLE, 16'd1, 8'd200, -17'sd1, 20'd7);
    send_item(REQ_SET_CHILD, 16'd0, 8'd0, 17'sd1, 20'd0);
    // most negative reference names the last single node
    send_item(REQ_SET_CHILD, 16'd1, 8'd63, 17'h10000, 20'd0);
    send_item(REQ_SET_CHILD, 16'd0, 8'd1, -17'sd1, 20'd0);
    send_item(REQ_SET_CHILD, 16'd4095, 8'd2, -17'sd2, 20'd0);
    send_item(REQ_SET_CHILD, 16'hFFFF, 8'd3, 17'sd1, 20'd0);
    send_item(REQ_SET_CHILD, 16'd1, 8'd200, 17'sd1, 20'd0);
  endtask

  task automatic test_directed_words();
    send_query(code_stop);
    send_query(8'd0); send_query(code_stop);
    send_query(8'd0); send_query(8'd63); send_query(8'd63); send_query(8'd2);
    send_query(code_end);
    send_query(8'd1); send_query(8'd5); send_query(code_stop);
    send_query(8'd1); send_query(8'd6); send_query(code_stop);
    send_query(8'd9); send_query(8'd0); send_query(code_end);
    send_query(8'd100); send_query(code_stop);
    send_query(8'd0); send_query(code_skip); send_query(8'd63); send_query(code_stop);
  endtask

  task automatic test_code_priority();
    set_codes(8'd7, 8'd7, 8'd9);
    send_query(8'd0); send_query(8'd7); send_query(8'd9);
    set_codes(8'd9, 8'd9, 8'd9);
    send_query(8'd0); send_query(8'd9);
  endtask

  task automatic test_random_with_pressure();
    set_codes(SKIP_CODE_RST, STOP_CODE_RST, END_CODE_RST);
    run_traffic(250);
    settle();
    run_traffic(250);
  endtask

  task automatic test_random_no_idle();
    idle_on = 1'b0;
    run_traffic(300);
    idle_on = 1'b1;
  endtask

  task automatic test_random_code_sets();
    set_codes(8'd3, 8'd4, 8'd5);
    run_traffic(250);
    set_codes(8'd0, 8'd0, 8'd0);
    run_traffic(300);
    set_codes(8'd255, 8'd255, 8'd128);
    run_traffic(250);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_load_trie();
    test_directed_words();
    test_code_priority();
    test_random_with_pressure();
    test_random_no_idle();
    test_random_code_sets();
    settle();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/trwl_pkg.sv
rtl/trwl_branch_store.sv
rtl/trwl_single_store.sv
rtl/trwl_ctrl.sv
rtl/trie_word_lookup.sv
rtl/trwl_checker.sv
tb/trie_word_lookup_tb.sv
